// ----- rtl/ivfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivfr_pkg
// Shared types and constants of the IMU vector frame rotation and health block
// ----------------------------------------------------------------------------
package ivfr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF   = 16;
  localparam int AXES             = 3;
  localparam int TIME_W           = 64;
  localparam int STAT_W           = 4;
  localparam int HEALTH_W         = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int QDEPTH           = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DCM0   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DCM1   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DCM2   = 2'd3;

  typedef enum logic {
    KIND_FORCE = 1'b0,
    KIND_RATE  = 1'b1
  } kind_t;

  typedef enum logic [HEALTH_W-1:0] {
    HL_UNAVAIL = 2'd0,
    HL_SAFE    = 2'd1,
    HL_RISK    = 2'd2
  } health_t;

  typedef struct packed {
    kind_t   kind;
    logic    en;
    health_t health;
  } tag_t;

endpackage
`default_nettype wire

// ----- rtl/ivfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivfr_front
// Accept stage: health grading, 3x3 rotation and timestamp mean pipeline
// ----------------------------------------------------------------------------
module ivfr_front #(
  parameter int SW = ivfr_pkg::SAMPLE_WIDTH_DEF,
  parameter int CW = ivfr_pkg::COEF_WIDTH_DEF,
  parameter int QW = $bits(ivfr_pkg::tag_t) + ivfr_pkg::AXES * SW + ivfr_pkg::TIME_W
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst_n,
  input  wire logic                                                in_valid_i,
  output logic                                                     in_ready_o,
  input  wire ivfr_pkg::kind_t                                     kind_i,
  input  wire logic [ivfr_pkg::AXES-1:0][SW-1:0]                   comp_i,
  input  wire logic [ivfr_pkg::AXES-1:0][ivfr_pkg::TIME_W-1:0]     time_i,
  input  wire logic [ivfr_pkg::AXES-1:0][ivfr_pkg::STAT_W-1:0]     stat_i,
  input  wire logic                                                en_i,
  input  wire logic [ivfr_pkg::AXES-1:0][ivfr_pkg::AXES*CW-1:0]    dcm_i,
  input  wire logic                                                q_full_i,
  output logic                                                     push_o,
  output logic [QW-1:0]                                            push_data_o
);

  localparam int AXES   = ivfr_pkg::AXES;
  localparam int TIME_W = ivfr_pkg::TIME_W;
  localparam int DIG_W  = 16;
  localparam int DIGITS = TIME_W / DIG_W;
  localparam int NST    = DIGITS + 1;
  localparam int PW     = SW + CW;
  localparam int SUMW   = PW + 2;
  localparam int F      = CW - 2;
  localparam int RSW    = SUMW - F;
  localparam int DIV3_SHIFT = 20;
  localparam int DMW    = DIG_W + 2 + DIV3_SHIFT;
  localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 20'd349526;
  localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [1:0] DET_GOOD = 2'd0;
  localparam logic [1:0] DET_FAIL = 2'd1;

  function automatic ivfr_pkg::health_t grade(
    input logic [AXES-1:0][ivfr_pkg::STAT_W-1:0] st
  );
    logic all_valid;
    logic all_ok;
    all_valid = 1'b1;
    all_ok    = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      all_valid = all_valid & st[i][0];
      if (!(st[i][2:1] == DET_GOOD || (st[i][2:1] == DET_FAIL && st[i][3]))) begin
        all_ok = 1'b0;
      end
    end
    if (!all_valid) return ivfr_pkg::HL_UNAVAIL;
    return all_ok ? ivfr_pkg::HL_SAFE : ivfr_pkg::HL_RISK;
  endfunction

  // one base-2^16 digit of a divide by three, returns {quotient, remainder}
  function automatic logic [DIG_W+1:0] div3_step(input logic [1:0] rem,
                                                 input logic [DIG_W-1:0] dig);
    logic [DIG_W+1:0] v;
    logic [DMW-1:0]   prod;
    logic [DIG_W-1:0] q;
    logic [DIG_W+1:0] r3;
    v    = {rem, dig};
    prod = DMW'(v) * DMW'(DIV3_RECIP);
    q    = prod[DIV3_SHIFT +: DIG_W];
    r3   = v - {1'b0, q, 1'b0} - {2'b00, q};
    return {q, r3[1:0]};
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [RSW-1:0] x);
    logic [RSW-SW:0] top;
    top = x[RSW-1:SW-1];
    if (top == '0 || top == '1) return x[SW-1:0];
    return x[RSW-1] ? SMIN : SMAX;
  endfunction

  logic                      ce;
  logic [1:NST]              v_r;
  ivfr_pkg::kind_t           kind_r [1:NST];
  logic                      en_r   [1:NST];
  ivfr_pkg::health_t         hl_r   [1:NST];
  logic [TIME_W-1:0]         tq_r   [1:DIGITS][AXES];
  logic [1:0]                rem_r  [1:DIGITS][AXES];
  logic [TIME_W-1:0]         tq_nxt [1:DIGITS][AXES];
  logic [1:0]                rem_nxt[1:DIGITS][AXES];
  logic signed [PW-1:0]      prod_r  [AXES][AXES];
  logic signed [PW-1:0]      prod_nxt[AXES][AXES];
  logic signed [RSW-1:0]     rs_r    [AXES];
  logic signed [RSW-1:0]     rs_nxt  [AXES];
  logic signed [SW-1:0]      vec_r   [3:NST][AXES];
  logic signed [SW-1:0]      vec_nxt [AXES];
  logic [TIME_W-1:0]         tmean_r;
  logic [TIME_W-1:0]         tmean_nxt;
  ivfr_pkg::tag_t            tag_out;
  logic [AXES*SW-1:0]        vec_out;

  assign ce         = !v_r[NST] || !q_full_i;
  assign in_ready_o = ce;
  assign push_o     = v_r[NST] && !q_full_i;

  always_comb begin
    logic [DIG_W+1:0] st;
    logic [TIME_W-1:0] src;
    logic signed [SUMW-1:0] acc;
    for (int i = 0; i < AXES; i++) begin
      st = div3_step(2'b00, time_i[i][(DIGITS-1)*DIG_W +: DIG_W]);
      tq_nxt[1][i] = time_i[i];
      tq_nxt[1][i][(DIGITS-1)*DIG_W +: DIG_W] = st[DIG_W+1:2];
      rem_nxt[1][i] = st[1:0];
    end
    for (int s = 2; s <= DIGITS; s++) begin
      for (int i = 0; i < AXES; i++) begin
        src = tq_r[s-1][i];
        st  = div3_step(rem_r[s-1][i], src[(DIGITS-s)*DIG_W +: DIG_W]);
        tq_nxt[s][i] = src;
        tq_nxt[s][i][(DIGITS-s)*DIG_W +: DIG_W] = st[DIG_W+1:2];
        rem_nxt[s][i] = st[1:0];
      end
    end
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        prod_nxt[r][c] = PW'($signed(comp_i[c])) * PW'($signed(dcm_i[r][c*CW +: CW]));
      end
      acc = SUMW'(prod_r[r][0]) + SUMW'(prod_r[r][1]) + SUMW'(prod_r[r][2]) + HALF;
      rs_nxt[r]  = acc[SUMW-1:F];
      vec_nxt[r] = (hl_r[2] == ivfr_pkg::HL_UNAVAIL) ? '0 : sat(rs_r[r]);
    end
    tmean_nxt = (hl_r[DIGITS] == ivfr_pkg::HL_UNAVAIL) ? '0 :
                tq_r[DIGITS][0] + tq_r[DIGITS][1] + tq_r[DIGITS][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {in_valid_i, v_r[1:NST-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      kind_r[1] <= kind_i;
      en_r[1]   <= en_i;
      hl_r[1]   <= grade(stat_i);
      for (int s = 2; s <= NST; s++) begin
        kind_r[s] <= kind_r[s-1];
        en_r[s]   <= en_r[s-1];
        hl_r[s]   <= hl_r[s-1];
      end
      for (int s = 1; s <= DIGITS; s++) begin
        for (int i = 0; i < AXES; i++) begin
          tq_r[s][i]  <= tq_nxt[s][i];
          rem_r[s][i] <= rem_nxt[s][i];
        end
      end
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          prod_r[r][c] <= prod_nxt[r][c];
        end
        rs_r[r]     <= rs_nxt[r];
        vec_r[3][r] <= vec_nxt[r];
        for (int s = 4; s <= NST; s++) begin
          vec_r[s][r] <= vec_r[s-1][r];
        end
      end
      tmean_r <= tmean_nxt;
    end
  end

  always_comb begin
    tag_out.kind   = kind_r[NST];
    tag_out.en     = en_r[NST];
    tag_out.health = hl_r[NST];
    for (int r = 0; r < AXES; r++) begin
      vec_out[r*SW +: SW] = vec_r[NST][r];
    end
  end

  assign push_data_o = {tag_out, vec_out, tmean_r};

endmodule
`default_nettype wire

// ----- rtl/ivfr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivfr_queue
// Short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module ivfr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ivfr_pkg::QDEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      pop_data_o,
  output logic              valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full_o     = (cnt_r == CNT_W'(DEPTH));
  assign valid_o    = (cnt_r != '0);
  assign pop_data_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

// ----- rtl/ivfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivfr_back
// Force hold, result combining and output register
// ----------------------------------------------------------------------------
module ivfr_back #(
  parameter int SW    = ivfr_pkg::SAMPLE_WIDTH_DEF,
  parameter int QW    = $bits(ivfr_pkg::tag_t) + ivfr_pkg::AXES * SW + ivfr_pkg::TIME_W,
  parameter int OUT_W = ((6 * SW + 2 * ivfr_pkg::HEALTH_W + ivfr_pkg::TIME_W + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid_i,
  input  wire logic [QW-1:0] q_data_i,
  output logic               q_pop_o,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  localparam int AXES   = ivfr_pkg::AXES;
  localparam int TIME_W = ivfr_pkg::TIME_W;
  localparam int HW     = ivfr_pkg::HEALTH_W;
  localparam int FH_LSB = 2 * AXES * SW;
  localparam int RH_LSB = FH_LSB + HW;
  localparam int TS_LSB = RH_LSB + HW;

  ivfr_pkg::tag_t      tag;
  logic [AXES*SW-1:0]  vec;
  logic [TIME_W-1:0]   tmean;
  logic                pending_r;
  logic [AXES*SW-1:0]  held_vec_r;
  ivfr_pkg::health_t   held_hl_r;
  logic [TIME_W-1:0]   held_t_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    res_nxt;
  ivfr_pkg::health_t   fh;
  logic [TIME_W-1:0]   ts;

  assign {tag, vec, tmean} = q_data_i;
  assign q_pop_o    = q_valid_i && (tag.kind == ivfr_pkg::KIND_FORCE ||
                                    !out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    fh = pending_r ? held_hl_r : ivfr_pkg::HL_UNAVAIL;
    if (fh != ivfr_pkg::HL_UNAVAIL && tag.health != ivfr_pkg::HL_UNAVAIL) begin
      ts = {1'b0, held_t_r[TIME_W-1:1]} + {1'b0, tmean[TIME_W-1:1]};
    end else if (fh != ivfr_pkg::HL_UNAVAIL) begin
      ts = held_t_r;
    end else begin
      ts = tmean;
    end
    res_nxt = '0;
    if (tag.en) begin
      res_nxt[0 +: AXES*SW]       = (fh != ivfr_pkg::HL_UNAVAIL) ? held_vec_r : '0;
      res_nxt[AXES*SW +: AXES*SW] = vec;
      res_nxt[FH_LSB +: HW]       = fh;
      res_nxt[RH_LSB +: HW]       = tag.health;
      res_nxt[TS_LSB +: TIME_W]   = ts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop_o && tag.kind == ivfr_pkg::KIND_RATE) begin
        pending_r   <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (q_pop_o) begin
          pending_r <= tag.en;
        end
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o && tag.kind == ivfr_pkg::KIND_FORCE && tag.en) begin
      held_vec_r <= vec;
      held_hl_r  <= tag.health;
      held_t_r   <= tmean;
    end
    if (q_pop_o && tag.kind == ivfr_pkg::KIND_RATE) begin
      out_data_r <= res_nxt;
    end
  end

  a_rate_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_o && tag.kind == ivfr_pkg::KIND_RATE) |=> !pending_r)
    else $error("force still pending after rate transaction");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_o && tag.kind == ivfr_pkg::KIND_RATE && !tag.en) |=>
      (out_tvalid && out_tdata == '0))
    else $error("disabled result not all zero");

  a_unavail_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[FH_LSB +: HW] == ivfr_pkg::HL_UNAVAIL) |->
      (out_tdata[0 +: AXES*SW] == '0))
    else $error("unavailable force carries nonzero vector");

endmodule
`default_nettype wire

// ----- rtl/imu_vector_frame_rotate_health.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_vector_frame_rotate_health
// IMU force/rate rotation into the vehicle frame with health grading
//
//  channel  handshake                 contents
//  in_      in_tvalid / in_tready     tdata: samples, timestamps, status
//                                     tuser: vector kind
//  out_     out_tvalid / out_tready   tdata: force, rate, healths, timestamp
//  cfg_     cfg_wen                   index + data, no read-back
//
// one item accepted per cycle unless a full queue stalls the front; each rate
// item gives a result after 4-digit divide-by-3 timestamp steps plus mean add
// a 4-entry queue decouples the front pipeline from output stalls
// reset is synchronous active low and clears control state only
// ----------------------------------------------------------------------------
module imu_vector_frame_rotate_health #(
  parameter int SAMPLE_WIDTH = ivfr_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = ivfr_pkg::COEF_WIDTH_DEF,
  parameter int IN_TDATA_W   = ((3 * SAMPLE_WIDTH + 3 * ivfr_pkg::TIME_W
                                 + 3 * ivfr_pkg::STAT_W + 7) / 8) * 8,
  parameter int OUT_TDATA_W  = ((6 * SAMPLE_WIDTH + 2 * ivfr_pkg::HEALTH_W
                                 + ivfr_pkg::TIME_W + 7) / 8) * 8,
  parameter int CFG_W        = 3 * COEF_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // comp_x, comp_y, comp_z, time_x, time_y, time_z, status_x, status_y, status_z
  input  wire logic [IN_TDATA_W-1:0]          in_tdata,
  // vector_kind
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // force_out_x/y/z, rate_out_x/y/z, force_health, rate_health, out_timestamp
  output logic [OUT_TDATA_W-1:0]              out_tdata,
  input  wire logic                           cfg_wen,
  input  wire logic [ivfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_wdata
);

  localparam int AXES   = ivfr_pkg::AXES;
  localparam int TIME_W = ivfr_pkg::TIME_W;
  localparam int STAT_W = ivfr_pkg::STAT_W;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COEF_WIDTH;
  localparam int T_LSB  = AXES * SW;
  localparam int S_LSB  = T_LSB + AXES * TIME_W;
  localparam int QW     = $bits(ivfr_pkg::tag_t) + AXES * SW + TIME_W;
  localparam logic [CW-1:0] ONE_Q = CW'(1) << (CW - 2);

  logic                            enable_r;
  logic [AXES-1:0][CFG_W-1:0]      dcm_r;
  logic [AXES-1:0][SW-1:0]         comp;
  logic [AXES-1:0][TIME_W-1:0]     tstamp;
  logic [AXES-1:0][STAT_W-1:0]     stat;
  logic                            q_full;
  logic                            q_push;
  logic [QW-1:0]                   q_push_data;
  logic                            q_pop;
  logic [QW-1:0]                   q_pop_data;
  logic                            q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int r = 0; r < AXES; r++) begin
        dcm_r[r] <= CFG_W'(ONE_Q) << (r * CW);
      end
    end else if (cfg_wen) begin
      case (cfg_index)
        ivfr_pkg::REG_ENABLE: enable_r <= cfg_wdata[0];
        ivfr_pkg::REG_DCM0:   dcm_r[0] <= cfg_wdata;
        ivfr_pkg::REG_DCM1:   dcm_r[1] <= cfg_wdata;
        ivfr_pkg::REG_DCM2:   dcm_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      comp[i]   = in_tdata[i*SW +: SW];
      tstamp[i] = in_tdata[T_LSB + i*TIME_W +: TIME_W];
      stat[i]   = in_tdata[S_LSB + i*STAT_W +: STAT_W];
    end
  end

  ivfr_front #(
    .SW (SW),
    .CW (CW),
    .QW (QW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .kind_i      (ivfr_pkg::kind_t'(in_tuser)),
    .comp_i      (comp),
    .time_i      (tstamp),
    .stat_i      (stat),
    .en_i        (enable_r),
    .dcm_i       (dcm_r),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  ivfr_queue #(
    .W     (QW),
    .DEPTH (ivfr_pkg::QDEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .valid_o     (q_valid)
  );

  ivfr_back #(
    .SW    (SW),
    .QW    (QW),
    .OUT_W (OUT_TDATA_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_data_i   (q_pop_data),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
